// ===== rtl/dlrw_pkg.sv =====
// Package for the display-list row walker.
// Holds the item structs, row kind codes, register indexes and decode tables.
// Used by dlrw_ctrl, dlrw_datapath and display_list_row_walker.
package dlrw_pkg;

  localparam int SCREEN_ROWS_DEF      = 30;
  localparam int MAX_INSTRUCTIONS_DEF = 1024;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PLAYFIELD_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DMA_ENABLE      = 1'd1;

  localparam logic [1:0] ROW_TEXT   = 2'd0;
  localparam logic [1:0] ROW_BLANK  = 2'd1;
  localparam logic [1:0] ROW_SPACER = 2'd2;
  localparam logic [1:0] ROW_FILL   = 2'd3;

  localparam logic [7:0] OPC_MASK = 8'h4f;

  localparam logic [5:0] WIDE_TEXT   [4] = '{6'd0, 6'd32, 6'd40, 6'd48};
  localparam logic [5:0] NARROW_TEXT [4] = '{6'd0, 6'd16, 6'd20, 6'd24};
  localparam logic [5:0] GFX_WIDTH   [8] = '{6'd10, 6'd10, 6'd20, 6'd20,
                                             6'd20, 6'd40, 6'd40, 6'd40};
  localparam logic [3:0] GFX_LINES   [8] = '{4'd8, 4'd4, 4'd4, 4'd2,
                                             4'd1, 4'd2, 4'd1, 4'd1};

  typedef struct packed {
    logic [7:0] list_byte;
    logic       frame_start;
  } dlrw_in_t;

  typedef struct packed {
    logic [1:0]  row_kind;
    logic [15:0] screen_address;
    logic        address_valid;
    logic [5:0]  row_width;
    logic [4:0]  row_number;
    logic        last;
    logic        frame_done;
  } dlrw_out_t;

  typedef struct packed {
    logic       accept;
    logic       emit;
    logic [1:0] kind;
  } dlrw_cmd_t;

  typedef struct packed {
    logic plan_text;
    logic plan_spacer;
    logic plan_blank;
    logic plan_fill;
    logic out_free;
  } dlrw_status_t;

endpackage

// ===== rtl/display_list_row_walker.sv =====
// Display-list row walker, top level.
// Joins the controller dlrw_ctrl and the datapath dlrw_datapath; uses dlrw_pkg.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------
//   in      | input     | in_valid_i / in_stall_o | dlrw_in_t: byte, frame start
//   out     | output    | out_valid_o/out_stall_i | dlrw_out_t: one row
//   cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// The row sequencer issues the rows of each item into the output register,
// one row per cycle while the output is not stalled.
// A frame-ending item may produce up to SCREEN_ROWS fill rows.
// Out stall holds the sequencer; the next item is taken once its last row
// has entered the output register.
// Reset is asynchronous, active low, and needs no clearing pass.
module display_list_row_walker #(
  parameter int SCREEN_ROWS      = dlrw_pkg::SCREEN_ROWS_DEF,
  parameter int MAX_INSTRUCTIONS = dlrw_pkg::MAX_INSTRUCTIONS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  dlrw_pkg::dlrw_in_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output dlrw_pkg::dlrw_out_t             out_item_o,
  input  logic                            cfg_we_i,
  input  logic [dlrw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dlrw_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  dlrw_pkg::dlrw_cmd_t    cmd;
  dlrw_pkg::dlrw_status_t status;

  dlrw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dlrw_datapath #(
    .SCREEN_ROWS      (SCREEN_ROWS),
    .MAX_INSTRUCTIONS (MAX_INSTRUCTIONS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// ===== rtl/dlrw_ctrl.sv =====
// Controller for the display-list row walker.
// Takes in one item, then walks the planned rows one per cycle while the output is free.
// Depends on dlrw_pkg.
module dlrw_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  dlrw_pkg::dlrw_status_t status_i,
  output dlrw_pkg::dlrw_cmd_t    cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   any_plan;

  assign any_plan = status_i.plan_text | status_i.plan_spacer |
                    status_i.plan_blank | status_i.plan_fill;

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    cmd_o       = '0;
    cmd_o.kind  = dlrw_pkg::ROW_TEXT;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!any_plan) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.emit = status_i.out_free;
          if (status_i.plan_text) begin
            cmd_o.kind = dlrw_pkg::ROW_TEXT;
          end else if (status_i.plan_spacer) begin
            cmd_o.kind = dlrw_pkg::ROW_SPACER;
          end else if (status_i.plan_blank) begin
            cmd_o.kind = dlrw_pkg::ROW_BLANK;
          end else begin
            cmd_o.kind = dlrw_pkg::ROW_FILL;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/dlrw_datapath.sv =====
// Datapath for the display-list row walker.
// Holds frame state, config registers, the row plan and the output register.
// Depends on dlrw_pkg.
module dlrw_datapath #(
  parameter int SCREEN_ROWS      = dlrw_pkg::SCREEN_ROWS_DEF,
  parameter int MAX_INSTRUCTIONS = dlrw_pkg::MAX_INSTRUCTIONS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dlrw_pkg::dlrw_in_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output dlrw_pkg::dlrw_out_t               out_item_o,
  input  logic                              cfg_we_i,
  input  logic [dlrw_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dlrw_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  dlrw_pkg::dlrw_cmd_t               cmd_i,
  output dlrw_pkg::dlrw_status_t            status_o
);

  localparam int RW = $clog2(SCREEN_ROWS + 1);
  localparam int CW = $clog2(MAX_INSTRUCTIONS + 1);
  localparam logic [RW-1:0] ROWS_MAX  = RW'(SCREEN_ROWS);
  localparam logic [CW-1:0] INSTR_MAX = CW'(MAX_INSTRUCTIONS);

  typedef enum logic [1:0] {
    PH_OPCODE,
    PH_ADDR_LO,
    PH_ADDR_HI
  } phase_e;

  // config
  logic [1:0] pf_q;
  logic       dma_q;

  // frame state
  phase_e        phase_q, phase_d;
  logic [7:0]    pending_q, pending_d;
  logic [7:0]    low_q, low_d;
  logic [2:0]    blank_q, blank_d;
  logic [15:0]   addr_q, addr_d;
  logic          loaded_q, loaded_d;
  logic [RW-1:0] rows_q, rows_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ended_q, ended_d;

  // row plan
  logic          p_text_q, p_text_d;
  logic          p_spacer_q, p_spacer_d;
  logic          p_blank_q, p_blank_d;
  logic          p_fill_q, p_fill_d;
  logic [15:0]   text_addr_q, text_addr_d;
  logic [5:0]    text_wid_q, text_wid_d;

  // output register
  logic                out_valid_q, out_valid_d;
  dlrw_pkg::dlrw_out_t out_q, out_d;

  // decode temporaries
  phase_e        phase_c;
  logic [7:0]    pending_c, low_c;
  logic [2:0]    blank_c;
  logic [15:0]   addr_c;
  logic          loaded_c, ended_c;
  logic [CW-1:0] cnt_c, cnt_n;
  logic          do_finish, jvb;
  logic [7:0]    instr;
  logic [3:0]    mode;
  logic [3:0]    bl_new;
  logic [5:0]    wid;
  logic [RW-1:0] rows_n;
  logic          done, more;
  logic          out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    phase_d     = phase_q;
    pending_d   = pending_q;
    low_d       = low_q;
    blank_d     = blank_q;
    addr_d      = addr_q;
    loaded_d    = loaded_q;
    rows_d      = rows_q;
    cnt_d       = cnt_q;
    ended_d     = ended_q;
    p_text_d    = p_text_q;
    p_spacer_d  = p_spacer_q;
    p_blank_d   = p_blank_q;
    p_fill_d    = p_fill_q;
    text_addr_d = text_addr_q;
    text_wid_d  = text_wid_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    phase_c   = phase_q;
    pending_c = pending_q;
    low_c     = low_q;
    blank_c   = blank_q;
    addr_c    = addr_q;
    loaded_c  = loaded_q;
    ended_c   = ended_q;
    cnt_c     = cnt_q;
    if (in_item_i.frame_start) begin
      phase_c   = PH_OPCODE;
      pending_c = '0;
      low_c     = '0;
      blank_c   = '0;
      addr_c    = '0;
      loaded_c  = 1'b0;
      ended_c   = 1'b0;
      cnt_c     = '0;
    end

    do_finish = 1'b0;
    jvb       = 1'b0;
    instr     = in_item_i.list_byte;
    mode      = '0;
    bl_new    = {1'b0, blank_c};
    wid       = '0;
    cnt_n     = cnt_c;
    rows_n    = rows_q + RW'(1);
    done      = 1'b0;
    more      = 1'b0;

    if (cmd_i.accept && dma_q) begin
      if (in_item_i.frame_start) begin
        phase_d   = phase_c;
        pending_d = pending_c;
        low_d     = low_c;
        blank_d   = blank_c;
        addr_d    = addr_c;
        loaded_d  = loaded_c;
        rows_d    = '0;
        cnt_d     = cnt_c;
        ended_d   = ended_c;
      end
      p_text_d   = 1'b0;
      p_spacer_d = 1'b0;
      p_blank_d  = 1'b0;
      p_fill_d   = 1'b0;
      if (!ended_c) begin
        case (phase_c)
          PH_ADDR_LO: begin
            low_d   = in_item_i.list_byte;
            phase_d = PH_ADDR_HI;
          end
          PH_ADDR_HI: begin
            addr_c    = {in_item_i.list_byte, low_c};
            loaded_c  = 1'b1;
            addr_d    = addr_c;
            loaded_d  = 1'b1;
            phase_d   = PH_OPCODE;
            do_finish = 1'b1;
            instr     = pending_c;
          end
          default: begin
            pending_d = in_item_i.list_byte;
            phase_d   = PH_OPCODE;
            if (in_item_i.list_byte[6] && (in_item_i.list_byte[3:0] >= 4'd2)) begin
              phase_d = PH_ADDR_LO;
            end else begin
              do_finish = 1'b1;
            end
          end
        endcase

        if (do_finish) begin
          mode = instr[3:0];
          if (mode == 4'd0) begin
            bl_new = {1'b0, blank_c} + {1'b0, instr[6:4]} + 4'd1;
          end else if (mode == 4'd1) begin
            jvb = instr[6];
          end else if (mode <= 4'd7) begin
            bl_new     = '0;
            p_text_d   = 1'b1;
            p_spacer_d = (mode == 4'd7);
            wid        = (mode <= 4'd5) ? dlrw_pkg::WIDE_TEXT[pf_q]
                                        : dlrw_pkg::NARROW_TEXT[pf_q];
          end else begin
            bl_new = {1'b0, blank_c} + dlrw_pkg::GFX_LINES[mode[2:0]];
            wid    = dlrw_pkg::GFX_WIDTH[mode[2:0]];
          end
          text_addr_d = addr_c;
          text_wid_d  = wid;
          if (jvb) begin
            p_fill_d = 1'b1;
          end else begin
            p_blank_d = bl_new[3];
            blank_d   = bl_new[2:0];
            if (loaded_c) begin
              addr_d = addr_c + 16'(wid);
            end
            if (cnt_c < INSTR_MAX) begin
              cnt_n = cnt_c + CW'(1);
            end
            cnt_d    = cnt_n;
            p_fill_d = (cnt_n >= INSTR_MAX);
          end
        end
      end
    end

    if (cmd_i.emit) begin
      done = (rows_n >= ROWS_MAX);
      case (cmd_i.kind)
        dlrw_pkg::ROW_TEXT:   more = p_spacer_q | p_blank_q | p_fill_q;
        dlrw_pkg::ROW_SPACER: more = p_blank_q | p_fill_q;
        dlrw_pkg::ROW_BLANK:  more = p_fill_q;
        default:              more = 1'b1;
      endcase
      out_valid_d          = 1'b1;
      out_d.row_kind       = cmd_i.kind;
      out_d.screen_address = (cmd_i.kind == dlrw_pkg::ROW_TEXT && loaded_q) ?
                             text_addr_q : 16'd0;
      out_d.address_valid  = loaded_q;
      out_d.row_width      = (cmd_i.kind == dlrw_pkg::ROW_TEXT) ? text_wid_q : 6'd0;
      out_d.row_number     = 5'(rows_q);
      out_d.last           = done || !more;
      out_d.frame_done     = done;
      rows_d               = rows_n;
      if (done) begin
        ended_d    = 1'b1;
        p_text_d   = 1'b0;
        p_spacer_d = 1'b0;
        p_blank_d  = 1'b0;
        p_fill_d   = 1'b0;
      end else begin
        case (cmd_i.kind)
          dlrw_pkg::ROW_TEXT:   p_text_d   = 1'b0;
          dlrw_pkg::ROW_SPACER: p_spacer_d = 1'b0;
          dlrw_pkg::ROW_BLANK:  p_blank_d  = 1'b0;
          default:              p_fill_d   = 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pf_q        <= 2'd2;
      dma_q       <= 1'b1;
      phase_q     <= PH_OPCODE;
      pending_q   <= '0;
      low_q       <= '0;
      blank_q     <= '0;
      addr_q      <= '0;
      loaded_q    <= 1'b0;
      rows_q      <= '0;
      cnt_q       <= '0;
      ended_q     <= 1'b0;
      p_text_q    <= 1'b0;
      p_spacer_q  <= 1'b0;
      p_blank_q   <= 1'b0;
      p_fill_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          dlrw_pkg::REG_PLAYFIELD_WIDTH: pf_q  <= cfg_data_i[1:0];
          dlrw_pkg::REG_DMA_ENABLE:      dma_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      phase_q     <= phase_d;
      pending_q   <= pending_d;
      low_q       <= low_d;
      blank_q     <= blank_d;
      addr_q      <= addr_d;
      loaded_q    <= loaded_d;
      rows_q      <= rows_d;
      cnt_q       <= cnt_d;
      ended_q     <= ended_d;
      p_text_q    <= p_text_d;
      p_spacer_q  <= p_spacer_d;
      p_blank_q   <= p_blank_d;
      p_fill_q    <= p_fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    text_addr_q <= text_addr_d;
    text_wid_q  <= text_wid_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign status_o.plan_text   = p_text_q;
  assign status_o.plan_spacer = p_spacer_q;
  assign status_o.plan_blank  = p_blank_q;
  assign status_o.plan_fill   = p_fill_q;
  assign status_o.out_free    = out_free;

endmodule
